### rtl/assert_macros.svh
// Assertion macros for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with an explicit clock and active-low reset.
`define VTCE_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define VTCE_ASSERT(label, prop, msg) `VTCE_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/vtce_pkg.sv
// Types, constants and codes for the vector terminal coordinate encoder.
`timescale 1ns / 1ps
`default_nettype none

package vtce_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned SCR_W      = 12;
  localparam int unsigned FIELD_W    = 5;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  // signed difference times gain widened by a zero sign bit
  localparam int unsigned PROD_W     = DIFF_W + GAIN_W + 1;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  // queue depth, a power of two
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  localparam logic [BYTE_W-1:0] CH_GS   = 8'o035;
  localparam logic [BYTE_W-1:0] CH_ESC  = 8'o033;
  localparam logic [BYTE_W-1:0] CH_FF   = 8'o014;
  localparam logic [BYTE_W-1:0] TAG_HI  = 8'o040;
  localparam logic [BYTE_W-1:0] TAG_LOY = 8'o140;
  localparam logic [BYTE_W-1:0] TAG_LOX = 8'o100;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_MOVE,
    OP_POINT,
    OP_ERASE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_GAIN_X,
    REG_GAIN_Y
  } cfg_reg_e;

  // Byte sequencer steps. CMD and ADDR resolve to a concrete byte step.
  typedef enum logic [3:0] {
    SQ_CMD,
    SQ_ADDR,
    SQ_ESC,
    SQ_FF,
    SQ_GS,
    SQ_HIY,
    SQ_LOY,
    SQ_HIX,
    SQ_LOX
  } seq_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic        [GAIN_W-1:0]  gain_x;
    logic        [GAIN_W-1:0]  gain_y;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [SCR_W-1:0] sx;
    logic [SCR_W-1:0] sy;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/vtce_if.sv
// Handshake channels: command words in, terminal bytes out, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface vtce_cmd_if import vtce_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, op, coord_x, coord_y, input ready);
  modport sink   (input valid, op, coord_x, coord_y, output ready);
endinterface

interface vtce_byte_if import vtce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface vtce_cfg_if import vtce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/vtce_queue.sv
// Small FIFO of scaled command words between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module vtce_queue import vtce_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/vtce_front.sv
// Front end: takes command words, offsets and scales both coordinates.
`timescale 1ns / 1ps
`default_nettype none

module vtce_front import vtce_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  vtce_cmd_if.sink        cmd_i,
  output logic            push_o,
  output item_t           item_o,
  input  logic            full_i
);

  // Round half up, clamp negatives to zero and large values to full scale.
  function automatic logic [SCR_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + $signed(PROD_W'(1) << (FRAC_W - 1));
    if (s[PROD_W-1]) begin
      return '0;
    end else if (|s[PROD_W-2:FRAC_W+SCR_W]) begin
      return '1;
    end else begin
      return s[FRAC_W+SCR_W-1:FRAC_W];
    end
  endfunction

  // stage 1: differences from origin
  logic                     v1_q;
  op_e                      op1_q;
  logic signed [DIFF_W-1:0] dx1_q, dy1_q;
  // stage 2: products
  logic                     v2_q;
  op_e                      op2_q;
  logic signed [PROD_W-1:0] px2_q, py2_q;

  logic                     en1, en2;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] px, py;

  assign push_o      = v2_q && !full_i;
  assign en2         = !v2_q || !full_i;
  assign en1         = !v1_q || en2;
  assign cmd_i.ready = en1;

  assign dx = DIFF_W'(cmd_i.coord_x) - DIFF_W'(cfg_i.origin_x);
  assign dy = DIFF_W'(cmd_i.coord_y) - DIFF_W'(cfg_i.origin_y);
  // gain is unsigned: a zero sign bit makes the product signed
  assign px = PROD_W'(dx1_q) * PROD_W'($signed({1'b0, cfg_i.gain_x}));
  assign py = PROD_W'(dy1_q) * PROD_W'($signed({1'b0, cfg_i.gain_y}));

  assign item_o.op = op2_q;
  assign item_o.sx = saturate(px2_q);
  assign item_o.sy = saturate(py2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= cmd_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && cmd_i.valid) begin
      op1_q <= op_e'(cmd_i.op);
      dx1_q <= dx;
      dy1_q <= dy;
    end
    if (en2 && v1_q) begin
      op2_q <= op1_q;
      px2_q <= px;
      py2_q <= py;
    end
  end

endmodule

`default_nettype wire

### rtl/vtce_back.sv
// Back end: byte sequencer with address history and output register.
`timescale 1ns / 1ps
`default_nettype none

module vtce_back import vtce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       busy_o,
  vtce_byte_if.source out_o
);

  logic                busy_q, busy_d;
  seq_e                seq_q, seq_d;
  logic                second_q, second_d;
  item_t               cur_q, cur_d;
  logic                hv_q, hv_d;
  logic [FIELD_W-1:0]  shy_q, shy_d;
  logic [FIELD_W-1:0]  shx_q, shx_d;
  logic [FIELD_W-1:0]  sly_q, sly_d;
  logic                ov_q, ov_d;
  logic [BYTE_W-1:0]   ob_q, ob_d;
  logic                ol_q, ol_d;

  logic [FIELD_W-1:0]  hix, hiy, lox, loy;
  logic                chg_hix, ld, fin;
  seq_e                addr_first, eff;

  assign hix = cur_q.sx[SCR_W-1 -: FIELD_W];
  assign hiy = cur_q.sy[SCR_W-1 -: FIELD_W];
  assign lox = cur_q.sx[SCR_W-FIELD_W-1 -: FIELD_W];
  assign loy = cur_q.sy[SCR_W-FIELD_W-1 -: FIELD_W];

  assign chg_hix = !hv_q || (hix != shx_q);
  assign ld      = !ov_q || out_o.ready;

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.last     = ol_q;
  assign busy_o         = busy_q;

  // first byte still owed for the current address, from the history as it stands now
  always_comb begin
    if (!hv_q || (hiy != shy_q)) begin
      addr_first = SQ_HIY;
    end else if (chg_hix || (loy != sly_q)) begin
      addr_first = SQ_LOY;
    end else begin
      addr_first = SQ_LOX;
    end
  end

  always_comb begin
    unique case (seq_q)
      SQ_CMD: begin
        if (cur_q.op == OP_ERASE) begin
          eff = SQ_ESC;
        end else if (cur_q.op == OP_DRAW) begin
          eff = addr_first;
        end else begin
          eff = SQ_GS;
        end
      end
      SQ_ADDR: eff = addr_first;
      default: eff = seq_q;
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    seq_d    = seq_q;
    second_d = second_q;
    cur_d    = cur_q;
    hv_d     = hv_q;
    shy_d    = shy_q;
    shx_d    = shx_q;
    sly_d    = sly_q;
    ov_d     = ov_q;
    ob_d     = ob_q;
    ol_d     = ol_q;
    fin      = 1'b0;
    pop_o    = 1'b0;

    if (ld) begin
      ov_d = busy_q;
      ol_d = 1'b0;
      if (busy_q) begin
        unique case (eff)
          SQ_ESC: begin
            ob_d  = CH_ESC;
            seq_d = SQ_FF;
          end
          SQ_FF: begin
            ob_d = CH_FF;
            ol_d = 1'b1;
            hv_d = 1'b0;
          end
          SQ_GS: begin
            ob_d  = CH_GS;
            seq_d = SQ_ADDR;
          end
          SQ_HIY: begin
            ob_d  = TAG_HI | BYTE_W'(hiy);
            shy_d = hiy;
            // history flag only rises on low-x, so pick the next step here
            seq_d = (chg_hix || (loy != sly_q)) ? SQ_LOY : SQ_LOX;
          end
          SQ_LOY: begin
            ob_d  = TAG_LOY | BYTE_W'(loy);
            sly_d = loy;
            seq_d = chg_hix ? SQ_HIX : SQ_LOX;
          end
          SQ_HIX: begin
            ob_d  = TAG_HI | BYTE_W'(hix);
            shx_d = hix;
            seq_d = SQ_LOX;
          end
          SQ_LOX: begin
            ob_d = TAG_LOX | BYTE_W'(lox);
            hv_d = 1'b1;
            // point: the repeat address only needs low-x
            if ((cur_q.op == OP_POINT) && !second_q) begin
              second_d = 1'b1;
              seq_d    = SQ_LOX;
            end else begin
              ol_d = 1'b1;
            end
          end
          default: begin
            ob_d = '0;
            ol_d = 1'b1;
          end
        endcase
        fin = ol_d;
      end

      if ((!busy_q || fin) && !empty_i) begin
        pop_o    = 1'b1;
        cur_d    = item_i;
        seq_d    = SQ_CMD;
        second_d = 1'b0;
        busy_d   = 1'b1;
      end else if (fin) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      seq_q    <= SQ_CMD;
      second_q <= 1'b0;
      hv_q     <= 1'b0;
      shy_q    <= '0;
      shx_q    <= '0;
      sly_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      seq_q    <= seq_d;
      second_q <= second_d;
      hv_q     <= hv_d;
      shy_q    <= shy_d;
      shx_q    <= shx_d;
      sly_q    <= sly_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

endmodule

`default_nettype wire

### rtl/vector_terminal_coordinate_encoder_core.sv
// Top level of the vector terminal coordinate encoder.
//
//   channel  dir  payload                    accepted when
//   cfg_i    in   index, data                valid && ready (ready always high)
//   cmd_i    in   op, coord_x, coord_y       valid && ready
//   out_o    out  out_byte, last             valid && ready
//
// A command word passes two register stages (difference, multiply) and is rounded
// and clamped on its way into a four-entry queue; the back-end sequencer then
// sends one byte per cycle while out_o is ready, 1 to 6 bytes per word, six for
// a point command that needs a full address; a word taken while idle is loaded
// before its bytes start. Output stalls fill the queue before cmd_i.ready drops.
// Reset clears the history and the config registers to origin 0 and gain 1.0.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vector_terminal_coordinate_encoder_core import vtce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vtce_cfg_if.sink    cfg_i,
  vtce_cmd_if.sink    cmd_i,
  vtce_byte_if.source out_o
);

  cfg_t    cfg_q;
  logic    q_push, q_pop, bk_busy;
  item_t   q_in, q_out;
  q_stat_t q_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.gain_x   <= GAIN_RESET;
      cfg_q.gain_y   <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ORIGIN_X: cfg_q.origin_x <= cfg_i.data[COORD_W-1:0];
        REG_ORIGIN_Y: cfg_q.origin_y <= cfg_i.data[COORD_W-1:0];
        REG_GAIN_X:   cfg_q.gain_x   <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_Y:   cfg_q.gain_y   <= cfg_i.data[GAIN_W-1:0];
      endcase
    end
  end

  vtce_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd_i),
    .push_o (q_push),
    .item_o (q_in),
    .full_i (q_stat.full)
  );

  vtce_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  vtce_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_out),
    .empty_i (q_stat.empty),
    .pop_o   (q_pop),
    .busy_o  (bk_busy),
    .out_o   (out_o)
  );

  `VTCE_ASSERT(a_q_full_empty, !(q_stat.full && q_stat.empty), "queue full and empty at once")
  `VTCE_ASSERT(a_mid_word_busy, (out_o.valid && out_o.ready && !out_o.last) |-> bk_busy, "sequencer idle in the middle of a word")
  `VTCE_ASSERT(a_idle_only_empty, (!bk_busy && $past(bk_busy)) |-> $past(q_stat.empty), "sequencer went idle with words queued")
  `VTCE_ASSERT(a_pop_nonempty, q_pop |-> !q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire
